>>> hw/rtl/hsfd_pkg.sv
package hsfd_pkg;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned GAIN_W  = 15;
	localparam int unsigned PROD_W  = WORD_W + GAIN_W;
	localparam int unsigned QUOT_W  = 15;
	localparam int unsigned TEMP_W  = 18;
	localparam int unsigned HUM_W   = 15;

	// crc-8, poly 0x31, init 0xff, msb first, no final xor
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	// scale factors (full scale over 65535)
	localparam logic [GAIN_W-1:0] TEMP_GAIN = 15'd17500;
	localparam logic [GAIN_W-1:0] HUM_GAIN  = 15'd12500;

	localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 18'sd4500;
	localparam logic [QUOT_W-1:0]        HUM_OFFSET  = 15'd600;
	localparam logic [HUM_W-1:0]         HUM_MAX     = 15'd10000;
	localparam logic [QUOT_W-1:0]        HUM_TOP     = 15'd10600;

	// sentinels for a failed frame
	localparam logic [WORD_W-1:0]        RAW_INVALID  = 16'hFFFF;
	localparam logic signed [TEMP_W-1:0] TEMP_INVALID = -18'sd99999;
	localparam logic [HUM_W-1:0]         HUM_INVALID  = 15'd20000;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BUS      = 2'd1,
		ERR_TEMP_CRC = 2'd2,
		ERR_HUM_CRC  = 2'd3
	} err_code_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic              crc_ok;
		logic [WORD_W-1:0] raw;
		logic [QUOT_W-1:0] quot;
	} lane_res_t;

	function automatic logic [BYTE_W-1:0] crc8_byte(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/hsfd_lane.sv
module hsfd_lane (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [hsfd_pkg::BYTE_W-1:0]   high_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]   low_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]   check_byte,
	input  logic [hsfd_pkg::GAIN_W-1:0]   gain,
	output hsfd_pkg::lane_res_t           res
);
	import hsfd_pkg::*;

	logic [WORD_W-1:0] raw_w;
	logic [WORD_W-1:0] raw_s1;
	logic [BYTE_W-1:0] chk_s1;
	logic [BYTE_W-1:0] crc_hi_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W:0]   div_sum;
	logic              crc_ok;
	lane_res_t         res_s2;

	assign raw_w = {high_byte, low_byte};

	// stage 1: crc over the high byte, gain multiply
	always_ff @(posedge clk) begin
		if (en_s1) begin
			raw_s1    <= raw_w;
			chk_s1    <= check_byte;
			crc_hi_s1 <= crc8_byte(CRC_INIT, high_byte);
			prod_s1   <= PROD_W'({{GAIN_W{1'b0}}, raw_w} * {{WORD_W{1'b0}}, gain});
		end
	end

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 2^16
	assign div_sum = {1'b0, prod_s1}
		+ (PROD_W+1)'(prod_s1[PROD_W-1:WORD_W])
		+ (PROD_W+1)'(1);
	assign crc_ok  = (crc8_byte(crc_hi_s1, raw_s1[BYTE_W-1:0]) == chk_s1);

	// stage 2: finish crc, divide
	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2.crc_ok <= crc_ok;
			res_s2.raw    <= raw_s1;
			res_s2.quot   <= div_sum[WORD_W+QUOT_W-1:WORD_W];
		end
	end

	assign res = res_s2;

endmodule

>>> hw/rtl/hsfd_merge.sv
module hsfd_merge (
	input  logic                               clk,
	input  logic                               en,
	input  logic                               read_ok,
	input  hsfd_pkg::lane_res_t                temp_res,
	input  hsfd_pkg::lane_res_t                hum_res,
	output logic                               valid_res,
	output hsfd_pkg::err_code_t                error_code,
	output logic [hsfd_pkg::WORD_W-1:0]        temp_raw,
	output logic [hsfd_pkg::WORD_W-1:0]        hum_raw,
	output logic signed [hsfd_pkg::TEMP_W-1:0] temp_centi,
	output logic [hsfd_pkg::HUM_W-1:0]         hum_centi
);
	import hsfd_pkg::*;

	err_code_t                  err_d;
	logic signed [TEMP_W-1:0]   tc_d;
	logic [HUM_W-1:0]           hc_d;

	logic                       valid_q;
	err_code_t                  err_q;
	logic [WORD_W-1:0]          traw_q;
	logic [WORD_W-1:0]          hraw_q;
	logic signed [TEMP_W-1:0]   tc_q;
	logic [HUM_W-1:0]           hc_q;

	// bus failure wins, then temperature crc, then humidity crc
	always_comb begin
		if (!read_ok) begin
			err_d = ERR_BUS;
		end else if (!temp_res.crc_ok) begin
			err_d = ERR_TEMP_CRC;
		end else if (!hum_res.crc_ok) begin
			err_d = ERR_HUM_CRC;
		end else begin
			err_d = ERR_NONE;
		end
	end

	assign tc_d = $signed({{(TEMP_W-QUOT_W){1'b0}}, temp_res.quot}) - TEMP_OFFSET;

	always_comb begin
		if (hum_res.quot < HUM_OFFSET) begin
			hc_d = '0;
		end else if (hum_res.quot > HUM_TOP) begin
			hc_d = HUM_MAX;
		end else begin
			hc_d = hum_res.quot - HUM_OFFSET;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= err_d;
			if (err_d == ERR_NONE) begin
				valid_q <= 1'b1;
				traw_q  <= temp_res.raw;
				hraw_q  <= hum_res.raw;
				tc_q    <= tc_d;
				hc_q    <= hc_d;
			end else begin
				valid_q <= 1'b0;
				traw_q  <= RAW_INVALID;
				hraw_q  <= RAW_INVALID;
				tc_q    <= TEMP_INVALID;
				hc_q    <= HUM_INVALID;
			end
		end
	end

	assign valid_res  = valid_q;
	assign error_code = err_q;
	assign temp_raw   = traw_q;
	assign hum_raw    = hraw_q;
	assign temp_centi = tc_q;
	assign hum_centi  = hc_q;

endmodule

>>> hw/rtl/humidity_sensor_frame_decode.sv
// Decodes one six-byte measurement frame per item: temperature word and its
// crc-8, humidity word and its crc-8, plus a bus status flag. Two identical
// lanes check and scale the temperature and humidity words side by side;
// each lane runs the crc over its two bytes (poly 0x31, init 0xff) and
// divides gain*raw by 65535 with an add-and-shift trick instead of a divider.
// A merge stage picks the error code (bus failure first, then temperature
// crc, then humidity crc), applies the offsets and the humidity clamp, and
// holds the result in the output register. On any failure the raw words
// read 65535, temp_centi reads -99999 and hum_centi reads 20000.
// Throughput is one item per cycle while the output is not stalled; each
// item passes three register stages on the way to out_valid (lane
// stage 1: crc high byte and multiply, lane stage 2: crc low byte and divide,
// merge register). Each stage has its own valid bit, so
// a bubble anywhere lets a new item in even while a result sits stalled at
// the output. There is no kept state between items.
module humidity_sensor_frame_decode (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               read_ok,
	input  logic [hsfd_pkg::BYTE_W-1:0]        temp_high_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]        temp_low_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]        temp_check_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]        hum_high_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]        hum_low_byte,
	input  logic [hsfd_pkg::BYTE_W-1:0]        hum_check_byte,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               valid_res,
	output logic [1:0]                         error_code,
	output logic [hsfd_pkg::WORD_W-1:0]        temp_raw,
	output logic [hsfd_pkg::WORD_W-1:0]        hum_raw,
	output logic signed [hsfd_pkg::TEMP_W-1:0] temp_centi,
	output logic [hsfd_pkg::HUM_W-1:0]         hum_centi
);
	import hsfd_pkg::*;

	// per-stage occupancy
	logic      vld_s1;
	logic      vld_s2;
	logic      out_vld_q;
	logic      ok_s1;
	logic      ok_s2;

	// a stage may load when it is empty or its item moves on this cycle
	logic      rdy_out;
	logic      rdy_s2;
	logic      rdy_s1;

	lane_res_t temp_res;
	lane_res_t hum_res;
	err_code_t err_w;

	assign rdy_out  = !out_vld_q || !out_stall;
	assign rdy_s2   = !vld_s2 || rdy_out;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	// bus status rides alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ok_s1 <= read_ok;
		end
		if (rdy_s2) begin
			ok_s2 <= ok_s1;
		end
	end

	// temperature lane
	hsfd_lane u_temp_lane (
		.clk        (clk),
		.en_s1      (rdy_s1),
		.en_s2      (rdy_s2),
		.high_byte  (temp_high_byte),
		.low_byte   (temp_low_byte),
		.check_byte (temp_check_byte),
		.gain       (TEMP_GAIN),
		.res        (temp_res)
	);

	// humidity lane
	hsfd_lane u_hum_lane (
		.clk        (clk),
		.en_s1      (rdy_s1),
		.en_s2      (rdy_s2),
		.high_byte  (hum_high_byte),
		.low_byte   (hum_low_byte),
		.check_byte (hum_check_byte),
		.gain       (HUM_GAIN),
		.res        (hum_res)
	);

	// error priority, offsets, clamp, output register
	hsfd_merge u_merge (
		.clk        (clk),
		.en         (rdy_out),
		.read_ok    (ok_s2),
		.temp_res   (temp_res),
		.hum_res    (hum_res),
		.valid_res  (valid_res),
		.error_code (err_w),
		.temp_raw   (temp_raw),
		.hum_raw    (hum_raw),
		.temp_centi (temp_centi),
		.hum_centi  (hum_centi)
	);

	assign error_code = err_w;
	assign out_valid  = out_vld_q;

endmodule

>>> hw/rtl/hsfd_checker.sv
module hsfd_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               valid_res,
	input  logic [1:0]                         error_code,
	input  logic [hsfd_pkg::WORD_W-1:0]        temp_raw,
	input  logic [hsfd_pkg::WORD_W-1:0]        hum_raw,
	input  logic signed [hsfd_pkg::TEMP_W-1:0] temp_centi,
	input  logic [hsfd_pkg::HUM_W-1:0]         hum_centi
);
	import hsfd_pkg::*;

	// a stalled item stays on the port
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temp_raw) && $stable(hum_centi))
		else $error("stalled output item changed");

	// good flag and error code agree
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_res == (error_code == ERR_NONE)))
		else $error("valid_res disagrees with error_code");

	// failed frames carry the sentinels
	a_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> temp_raw == RAW_INVALID && hum_raw == RAW_INVALID
			&& temp_centi == TEMP_INVALID && hum_centi == HUM_INVALID)
		else $error("failed item without sentinel values");

	// good frames stay inside the scaled ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> hum_centi <= HUM_MAX
			&& temp_centi >= -TEMP_OFFSET && temp_centi <= 18'sd13000)
		else $error("converted value out of range");

endmodule

bind humidity_sensor_frame_decode hsfd_checker u_hsfd_checker (.*);

>>> dv/tb_humidity_sensor_frame_decode.sv
`timescale 1ns / 100ps

module tb_humidity_sensor_frame_decode;

	import hsfd_pkg::*;

	// scaling of the sensor words, in hundredths
	localparam int TEMP_SPAN  = 17500;
	localparam int TEMP_BASE  = -4500;
	localparam int HUM_SPAN   = 12500;
	localparam int HUM_BASE   = -600;
	localparam int HUM_CEIL   = 10000;
	localparam int FULL_SCALE = 65535;

	// run shape
	localparam int RANDOM_FRAMES    = 1630;
	localparam int STEADY_SENDER_AT = 1200;
	localparam int NO_IDLE_AT       = 1400;
	localparam int SETTLE_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT   = 400;

	// one frame as the sensor sends it, plus the bus status
	typedef struct {
		logic        read_ok;
		logic [15:0] temp_word;
		logic [7:0]  temp_crc;
		logic [15:0] hum_word;
		logic [7:0]  hum_crc;
	} frame_t;

	// one decoded reading as the block presents it
	typedef struct {
		logic                      valid_res;
		err_code_t                 error_code;
		logic [WORD_W-1:0]         temp_raw;
		logic [WORD_W-1:0]         hum_raw;
		logic signed [TEMP_W-1:0]  temp_centi;
		logic [HUM_W-1:0]          hum_centi;
	} reading_t;

	// which check bytes a generated frame gets wrong
	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_TEMP,
		FLAW_HUM,
		FLAW_BOTH
	} crc_flaw_t;

	// crc-8 over a whole word, bit by bit, msb first
	function automatic logic [7:0] word_crc(input logic [15:0] word);
		logic [7:0] r;
		logic       fb;
		r = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			fb = r[7] ^ word[i];
			r  = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// keeps the readings still owed by the block and checks them in order
	class reading_board;
		reading_t    owed_q[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned err_tally[4];

		function reading_t decode_frame(frame_t f);
			reading_t r;
			int       t;
			int       h;
			r.valid_res  = 1'b0;
			r.temp_raw   = RAW_INVALID;
			r.hum_raw    = RAW_INVALID;
			r.temp_centi = TEMP_INVALID;
			r.hum_centi  = HUM_INVALID;
			if (!f.read_ok) begin
				r.error_code = ERR_BUS;
			end else if (word_crc(f.temp_word) != f.temp_crc) begin
				r.error_code = ERR_TEMP_CRC;
			end else if (word_crc(f.hum_word) != f.hum_crc) begin
				r.error_code = ERR_HUM_CRC;
			end else begin
				t = TEMP_BASE + (TEMP_SPAN * int'(f.temp_word)) / FULL_SCALE;
				h = HUM_BASE + (HUM_SPAN * int'(f.hum_word)) / FULL_SCALE;
				if (h < 0) begin
					h = 0;
				end
				if (h > HUM_CEIL) begin
					h = HUM_CEIL;
				end
				r.valid_res  = 1'b1;
				r.error_code = ERR_NONE;
				r.temp_raw   = f.temp_word;
				r.hum_raw    = f.hum_word;
				r.temp_centi = t[TEMP_W-1:0];
				r.hum_centi  = h[HUM_W-1:0];
			end
			return r;
		endfunction

		function void note_frame(frame_t f);
			reading_t r;
			r = decode_frame(f);
			err_tally[r.error_code]++;
			owed_q.push_back(r);
		endfunction

		function void report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		function void compare_field(string name, logic signed [31:0] got,
				logic signed [31:0] want);
			if (got !== want) begin
				report($sformatf("reading %0d %s got %0d want %0d",
					checked, name, got, want));
			end
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("reading with no frame owed, error_code %0d",
					got.error_code));
				return;
			end
			want = owed_q.pop_front();
			compare_field("valid_res", got.valid_res, want.valid_res);
			compare_field("error_code", got.error_code, want.error_code);
			compare_field("temp_raw", got.temp_raw, want.temp_raw);
			compare_field("hum_raw", got.hum_raw, want.hum_raw);
			compare_field("temp_centi", got.temp_centi, want.temp_centi);
			compare_field("hum_centi", got.hum_centi, want.hum_centi);
			checked++;
		endfunction

		function int unsigned outstanding();
			return owed_q.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      read_ok;
	logic [BYTE_W-1:0]         temp_high_byte;
	logic [BYTE_W-1:0]         temp_low_byte;
	logic [BYTE_W-1:0]         temp_check_byte;
	logic [BYTE_W-1:0]         hum_high_byte;
	logic [BYTE_W-1:0]         hum_low_byte;
	logic [BYTE_W-1:0]         hum_check_byte;
	logic                      out_valid;
	logic                      out_stall;
	logic                      valid_res;
	logic [1:0]                error_code;
	logic [WORD_W-1:0]         temp_raw;
	logic [WORD_W-1:0]         hum_raw;
	logic signed [TEMP_W-1:0]  temp_centi;
	logic [HUM_W-1:0]          hum_centi;

	reading_board board = new();

	// idling switches, turned off toward the end of the run
	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;

	int unsigned quiet_cycles;

	humidity_sensor_frame_decode DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.read_ok         (read_ok),
		.temp_high_byte  (temp_high_byte),
		.temp_low_byte   (temp_low_byte),
		.temp_check_byte (temp_check_byte),
		.hum_high_byte   (hum_high_byte),
		.hum_low_byte    (hum_low_byte),
		.hum_check_byte  (hum_check_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.valid_res       (valid_res),
		.error_code      (error_code),
		.temp_raw        (temp_raw),
		.hum_raw         (hum_raw),
		.temp_centi      (temp_centi),
		.hum_centi       (hum_centi)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// builds a frame with correct check bytes, then spoils the ones asked for
	function automatic frame_t make_frame(input logic ok, input logic [15:0] tw,
			input logic [15:0] hw, input crc_flaw_t flaw);
		frame_t f;
		logic [7:0] spoil_t;
		logic [7:0] spoil_h;
		spoil_t     = 8'($urandom_range(1, 255));
		spoil_h     = 8'($urandom_range(1, 255));
		f.read_ok   = ok;
		f.temp_word = tw;
		f.hum_word  = hw;
		f.temp_crc  = word_crc(tw);
		f.hum_crc   = word_crc(hw);
		if (flaw == FLAW_TEMP || flaw == FLAW_BOTH) begin
			f.temp_crc = f.temp_crc ^ spoil_t;
		end
		if (flaw == FLAW_HUM || flaw == FLAW_BOTH) begin
			f.hum_crc = f.hum_crc ^ spoil_h;
		end
		return f;
	endfunction

	// raw words lean toward the ends of the range and the humidity clamp points
	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		case ($urandom_range(0, 11))
			0: begin
				w = 16'($urandom_range(0, 15));
			end
			1: begin
				w = 16'hFFFF - 16'($urandom_range(0, 15));
			end
			2: begin
				w = 16'($urandom_range(3100, 3200));
			end
			3: begin
				w = 16'($urandom_range(55500, 55650));
			end
			default: begin
				w = 16'($urandom);
			end
		endcase
		return w;
	endfunction

	// mostly well-formed frames, the rest bus faults, bad check bytes and noise
	function automatic frame_t random_frame();
		frame_t      f;
		int unsigned pick;
		logic [15:0] tw;
		logic [15:0] hw;
		pick = $urandom_range(0, 99);
		tw   = pick_word();
		hw   = pick_word();
		if (pick < 70) begin
			f = make_frame(1'b1, tw, hw, FLAW_NONE);
		end else if (pick < 78) begin
			f = make_frame(1'b0, tw, hw, crc_flaw_t'($urandom_range(0, 3)));
		end else if (pick < 86) begin
			f = make_frame(1'b1, tw, hw, FLAW_TEMP);
		end else if (pick < 92) begin
			f = make_frame(1'b1, tw, hw, FLAW_HUM);
		end else if (pick < 95) begin
			f = make_frame(1'b1, tw, hw, FLAW_BOTH);
		end else begin
			// check bytes as pure noise, now and then they match by chance
			f          = make_frame(1'b1, tw, hw, FLAW_NONE);
			f.temp_crc = 8'($urandom);
			f.hum_crc  = 8'($urandom);
		end
		return f;
	endfunction

	// presents one item at the falling edge and holds it until taken
	task automatic send_frame(input frame_t f);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid        <= 1'b1;
		read_ok         <= f.read_ok;
		temp_high_byte  <= f.temp_word[15:8];
		temp_low_byte   <= f.temp_word[7:0];
		temp_check_byte <= f.temp_crc;
		hum_high_byte   <= f.hum_word[15:8];
		hum_low_byte    <= f.hum_word[7:0];
		hum_check_byte  <= f.hum_crc;
		do @(posedge clk); while (in_stall);
		board.note_frame(f);
		@(negedge clk);
	endtask

	// sender holds off until the block has handed back every reading
	task automatic drain_readings();
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(negedge clk);
	endtask

	// result side: stall now and then in bursts of random length while idling is on
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (receiver_idles && $urandom_range(0, 6) == 0) begin
					stall_left = $urandom_range(1, 13);
				end
			end
		end
	end

	// every reading taken from the block is checked against the oldest owed one
	always @(posedge clk) begin
		reading_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.valid_res  = valid_res;
			seen.error_code = err_code_t'(error_code);
			seen.temp_raw   = temp_raw;
			seen.hum_raw    = hum_raw;
			seen.temp_centi = temp_centi;
			seen.hum_centi  = hum_centi;
			board.check_reading(seen);
		end
	end

	// watchdog: too long with nothing moving on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles, %0d readings owed",
				WATCHDOG_LIMIT, board.outstanding());
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		frame_t f;

		// every input known from the first instant
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		read_ok         = 1'b0;
		temp_high_byte  = '0;
		temp_low_byte   = '0;
		temp_check_byte = '0;
		hum_high_byte   = '0;
		hum_low_byte    = '0;
		hum_check_byte  = '0;
		quiet_cycles    = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// word extremes, both clamp ends of humidity
		send_frame(make_frame(1'b1, 16'h0000, 16'h0000, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'hFFFF, 16'hFFFF, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h0000, 16'hFFFF, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'hFFFF, 16'h0000, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'hAAAA, 16'h5555, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h5555, 16'hAAAA, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h8000, 16'h8000, FLAW_NONE));

		// humidity right around the low clamp (raw 3145..3147)
		send_frame(make_frame(1'b1, 16'h7FFF, 16'd3145, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h6666, 16'd3146, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h1234, 16'd3147, FLAW_NONE));

		// humidity right around the high clamp
		send_frame(make_frame(1'b1, 16'h4321, 16'd55570, FLAW_NONE));
		send_frame(make_frame(1'b1, 16'h0001, 16'd55576, FLAW_NONE));

		// bus failure wins over everything, whatever the check bytes say
		send_frame(make_frame(1'b0, 16'h2468, 16'h1357, FLAW_NONE));
		send_frame(make_frame(1'b0, 16'hFFFF, 16'hFFFF, FLAW_BOTH));
		f = '{read_ok: 1'b0, temp_word: 16'h0000, temp_crc: 8'h00,
			hum_word: 16'h0000, hum_crc: 8'h00};
		send_frame(f);

		// single-bit check byte errors at both ends of the byte
		f = make_frame(1'b1, 16'hBEEF, 16'h1234, FLAW_NONE);
		f.temp_crc = f.temp_crc ^ 8'h80;
		send_frame(f);
		f.temp_crc = f.temp_crc ^ 8'h81;
		send_frame(f);
		f = make_frame(1'b1, 16'hBEEF, 16'h1234, FLAW_NONE);
		f.hum_crc = f.hum_crc ^ 8'h01;
		send_frame(f);
		f.hum_crc = f.hum_crc ^ 8'h81;
		send_frame(f);

		// temperature error is reported even when humidity is also bad
		send_frame(make_frame(1'b1, 16'h3C3C, 16'hC3C3, FLAW_TEMP));
		send_frame(make_frame(1'b1, 16'h3C3C, 16'hC3C3, FLAW_HUM));
		send_frame(make_frame(1'b1, 16'h3C3C, 16'hC3C3, FLAW_BOTH));

		// let the pipeline run dry once before the random part
		drain_readings();

		for (int n = 0; n < RANDOM_FRAMES; n++) begin
			if (n == STEADY_SENDER_AT) begin
				sender_idles = 1'b0;
			end
			if (n == NO_IDLE_AT) begin
				drain_readings();
				receiver_idles = 1'b0;
			end
			send_frame(random_frame());
		end
		in_valid <= 1'b0;

		// wait for the last readings, then settle for anything stray
		while (board.outstanding() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("frames decoded: %0d good, %0d bus fault, %0d temp crc, %0d hum crc",
			board.err_tally[ERR_NONE], board.err_tally[ERR_BUS],
			board.err_tally[ERR_TEMP_CRC], board.err_tally[ERR_HUM_CRC]);
		$display("readings checked: %0d, mismatches: %0d",
			board.checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_lane.sv
hw/rtl/hsfd_merge.sv
hw/rtl/humidity_sensor_frame_decode.sv
hw/rtl/hsfd_checker.sv
dv/tb_humidity_sensor_frame_decode.sv
